FILE: sv/sha1_message_digest_macros.svh
// assertion macros for the sha1 message digest block
// used by the top level only, needs nothing else

`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// same-cycle implication, checked out of reset
`define SHA1_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SHA1_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sha1_pkg.sv
// shared types, constants and round functions for the sha1 digest block
// no dependencies

`timescale 1ns / 1ps

package sha1_pkg;

    localparam int WORD_W      = 32;
    localparam int FILL_W      = 6;
    localparam int COUNT_W     = 61;
    localparam int LEN_W       = 64;
    localparam int HASH_WORDS  = 5;
    localparam int SCHED_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int CNT_W       = 7;
    localparam int WNUM_W      = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    // length field starts at byte 56 of the last block (bit 448 of 512)
    localparam logic [FILL_W-1:0] LEN_FILL = 6'd56;
    localparam logic [FILL_W-1:0] LEN_LO_FILL = 6'd60;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [CNT_W-1:0] LOAD_LAST  = 7'd15;
    localparam logic [CNT_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [WNUM_W-1:0] WORD_LAST = 3'd4;

    localparam logic [WORD_W-1:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              final_block;
    } word_item_t;

    function automatic logic [WORD_W-1:0] round_f(
        input logic [CNT_W-1:0]  t,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            r = b ^ c ^ d;
        end else if (t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [CNT_W-1:0] t);
        logic [WORD_W-1:0] r;
        if (t < 7'd20) begin
            r = K_0;
        end else if (t < 7'd40) begin
            r = K_1;
        end else if (t < 7'd60) begin
            r = K_2;
        end else begin
            r = K_3;
        end
        return r;
    endfunction

endpackage

FILE: sv/sha1_front.sv
// front end: packs message bytes into big-endian words, adds padding and length
// depends on sha1_pkg

`timescale 1ns / 1ps

module sha1_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  logic [7:0]          msg_byte,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                push_valid,
    output sha1_pkg::word_item_t push_item,
    input  logic                fifo_full
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        PAD_ONE,
        PAD_ZERO,
        LEN_HI,
        LEN_LO
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [LEN_W-1:0]      bit_len;
    logic                  accept;
    logic                  byte_go;
    logic [7:0]            byte_val;
    logic [FILL_W-1:0]     fill_inc;

    assign msg_stall  = fifo_full || (state_reg != IDLE);
    assign accept     = msg_valid && !msg_stall;
    assign bit_len    = {count_reg, 3'b000};
    assign fill_inc   = fill_reg + 6'd1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        word_next  = word_reg;
        byte_go    = 1'b0;
        byte_val   = ZERO_BYTE;
        push_valid = 1'b0;
        push_item  = '{word: word_reg, final_block: 1'b0};

        unique case (state_reg)
            IDLE:
            begin
                if (accept) begin
                    if (byte_present) begin
                        byte_go    = 1'b1;
                        byte_val   = msg_byte;
                        count_next = count_reg + 61'd1;
                    end
                    if (end_of_message) begin
                        state_next = PAD_ONE;
                    end
                end
            end
            PAD_ONE:
            begin
                if (!fifo_full) begin
                    byte_go    = 1'b1;
                    byte_val   = PAD_BYTE;
                    state_next = (fill_inc == LEN_FILL) ? LEN_HI : PAD_ZERO;
                end
            end
            PAD_ZERO:
            begin
                if (!fifo_full) begin
                    byte_go    = 1'b1;
                    byte_val   = ZERO_BYTE;
                    state_next = (fill_inc == LEN_FILL) ? LEN_HI : PAD_ZERO;
                end
            end
            LEN_HI:
            begin
                if (!fifo_full) begin
                    push_valid = 1'b1;
                    push_item  = '{word: bit_len[LEN_W-1:WORD_W], final_block: 1'b0};
                    fill_next  = LEN_LO_FILL;
                    state_next = LEN_LO;
                end
            end
            LEN_LO:
            begin
                if (!fifo_full) begin
                    push_valid = 1'b1;
                    push_item  = '{word: bit_len[WORD_W-1:0], final_block: 1'b1};
                    fill_next  = '0;
                    count_next = '0;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        if (byte_go) begin
            word_next = {word_reg[WORD_W-9:0], byte_val};
            fill_next = fill_inc;
            if (fill_reg[1:0] == 2'b11) begin
                push_valid = 1'b1;
                push_item  = '{word: word_next, final_block: 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            word_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            word_reg  <= word_next;
        end
    end

endmodule

FILE: sv/sha1_fifo.sv
// short word queue between the byte packer and the compression core
// depends on sha1_pkg

`timescale 1ns / 1ps

module sha1_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  sha1_pkg::word_item_t push_item,
    output logic                 full,
    output logic                 pop_valid,
    output sha1_pkg::word_item_t pop_item,
    input  logic                 pop_stall
);
    import sha1_pkg::*;

    word_item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    push, pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_valid && !pop_stall;

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 3'd1;
                2'b01:   count_reg <= count_reg - 3'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: sv/sha1_core.sv
// back end: message schedule, 80-round compression and digest word output
// depends on sha1_pkg

`timescale 1ns / 1ps

module sha1_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    input  sha1_pkg::word_item_t word_item,
    output logic                 word_stall,
    output logic                 digest_valid,
    input  logic                 digest_stall,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_number,
    output logic                 final_word
);
    import sha1_pkg::*;

    typedef enum logic [1:0] {
        LOAD,
        ROUND,
        ADD,
        SEND
    } core_state_t;

    core_state_t       state_reg;
    logic [WORD_W-1:0] win_reg [SCHED_WORDS];
    logic [WORD_W-1:0] wv_reg [HASH_WORDS];
    logic [WORD_W-1:0] h_reg [HASH_WORDS];
    logic [CNT_W-1:0]  cnt_reg;
    logic              final_reg;
    logic              take;
    logic [WORD_W-1:0] w_mix, w_new, tmp;
    logic [WNUM_W-1:0] wnum;

    assign word_stall   = (state_reg != LOAD);
    assign take         = word_valid && !word_stall;
    assign wnum         = cnt_reg[WNUM_W-1:0];
    assign digest_valid = (state_reg == SEND);
    assign digest_word  = h_reg[wnum];
    assign word_number  = wnum;
    assign final_word   = (wnum == WORD_LAST);

    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
    assign tmp   = {wv_reg[0][WORD_W-6:0], wv_reg[0][WORD_W-1:WORD_W-5]}
                 + round_f(cnt_reg, wv_reg[1], wv_reg[2], wv_reg[3])
                 + wv_reg[4] + win_reg[0] + round_k(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= LOAD;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                h_reg[i]  <= H_INIT[i];
                wv_reg[i] <= '0;
            end
            for (int i = 0; i < SCHED_WORDS; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                LOAD:
                begin
                    if (take) begin
                        for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                            win_reg[i] <= win_reg[i+1];
                        end
                        win_reg[SCHED_WORDS-1] <= word_item.word;
                        final_reg <= word_item.final_block;
                        if (cnt_reg == LOAD_LAST) begin
                            cnt_reg <= '0;
                            for (int i = 0; i < HASH_WORDS; i++) begin
                                wv_reg[i] <= h_reg[i];
                            end
                            state_reg <= ROUND;
                        end else begin
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                end
                ROUND:
                begin
                    for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[SCHED_WORDS-1] <= w_new;
                    wv_reg[4] <= wv_reg[3];
                    wv_reg[3] <= wv_reg[2];
                    wv_reg[2] <= {wv_reg[1][1:0], wv_reg[1][WORD_W-1:2]};
                    wv_reg[1] <= wv_reg[0];
                    wv_reg[0] <= tmp;
                    if (cnt_reg == ROUND_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ADD;
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ADD:
                begin
                    for (int i = 0; i < HASH_WORDS; i++) begin
                        h_reg[i] <= h_reg[i] + wv_reg[i];
                    end
                    state_reg <= final_reg ? SEND : LOAD;
                end
                SEND:
                begin
                    if (!digest_stall) begin
                        if (wnum == WORD_LAST) begin
                            cnt_reg <= '0;
                            for (int i = 0; i < HASH_WORDS; i++) begin
                                h_reg[i] <= H_INIT[i];
                            end
                            state_reg <= LOAD;
                        end else begin
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= LOAD;
                end
            endcase
        end
    end

endmodule

FILE: sv/sha1_message_digest.sv
// top level of the sha1 message digest block: packer, word queue, compression core
// depends on sha1_pkg, sha1_front, sha1_fifo, sha1_core and the assertion macros
//
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+--------------------------------------
// message  | msg_valid    | msg_stall    | msg_byte, byte_present, end_of_message
// digest   | digest_valid | digest_stall | digest_word, word_number, final_word
//
// message bytes are taken one per cycle while the 4-word queue has room and the packer is not padding
// each 64-byte block costs 16 loads, 80 rounds and one add in the core, and the queue
// holds only 16 bytes, so message input stalls once the queue fills while the core works
// after the last transfer the packer emits pad bytes and length words, stalling while the
// queue is full, then the core finishes its rounds and add before the five digest transfers
// rst_n clears all control state asynchronously; a stalled digest word holds

`timescale 1ns / 1ps
`include "sha1_message_digest_macros.svh"

module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  msg_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);
    import sha1_pkg::*;

    logic       push_valid;
    word_item_t push_item;
    logic       fifo_full;
    logic       pop_valid;
    word_item_t pop_item;
    logic       pop_stall;

    sha1_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .msg_byte       (msg_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .push_valid     (push_valid),
        .push_item      (push_item),
        .fifo_full      (fifo_full)
    );

    sha1_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_stall  (pop_stall)
    );

    sha1_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (pop_valid),
        .word_item    (pop_item),
        .word_stall   (pop_stall),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word  (digest_word),
        .word_number  (word_number),
        .final_word   (final_word)
    );

    `SHA1_ASSERT_NOW(a_word_number_range, clk, rst_n, digest_valid, word_number <= 3'd4, "digest word number out of range")
    `SHA1_ASSERT_NOW(a_final_on_last, clk, rst_n, digest_valid, final_word == (word_number == 3'd4), "final flag not on the fifth word")
    `SHA1_ASSERT_NEXT(a_gap_after_final, clk, rst_n, digest_valid && !digest_stall && final_word, !digest_valid, "digest valid right after final transfer")

endmodule
